// ----- design/merge_sorter_macros.svh -----
// ---------------------------------------------------------------------------
// merge_sorter_macros.svh
// Assertion macros used by the merge_sorter RTL.
// ---------------------------------------------------------------------------
`ifndef MERGE_SORTER_MACROS_SVH
`define MERGE_SORTER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define MS_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define MS_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ms_pkg.sv -----
// ---------------------------------------------------------------------------
// ms_pkg
// Types and constants of the insertion-chain sorter.
// ---------------------------------------------------------------------------
`default_nettype none

package ms_pkg;

	localparam int unsigned DEFAULT_MAX_ELEMS = 16;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} in_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               last_out;
		logic               overflow;
	} out_t;

	// Contents of one cell of the chain.
	typedef struct packed {
		logic               valid;
		logic signed [31:0] value;
	} slot_t;

	// Operation applied to every cell in a cycle.
	typedef struct packed {
		logic insert;
		logic pop;
	} ctl_t;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ----- design/ms_cell.sv -----
// ---------------------------------------------------------------------------
// ms_cell
// One cell of the sorting chain: holds one element, makes room for a new
// item by passing its element to the right, or takes its right neighbor's
// element while the chain drains.
// ---------------------------------------------------------------------------
`default_nettype none

module ms_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ms_pkg::ctl_t       ctl,
	input  wire logic signed [31:0] new_value,
	input  wire ms_pkg::slot_t      left,
	input  wire logic               left_gt,
	input  wire ms_pkg::slot_t      right,
	output ms_pkg::slot_t           slot,
	output logic                    gt
);

	logic               valid_q;
	logic signed [31:0] value_q;

	// An empty cell counts as larger than anything, so equal values stay
	// in arrival order.
	assign gt   = !valid_q || (value_q > new_value);
	assign slot = '{valid: valid_q, value: value_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= right.valid;
		end else if (ctl.insert && gt) begin
			valid_q <= left_gt ? left.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			value_q <= right.value;
		end else if (ctl.insert && gt) begin
			value_q <= left_gt ? left.value : new_value;
		end
	end

endmodule

`default_nettype wire

// ----- design/merge_sorter.sv -----
// The closing item moves the state register to ST_EMIT, whose first pop loads
// the output register behind res_valid (later only while the previous set's
// final result still waits); then one result per cycle while res_stall is low.
// Throughput: one element per cycle while loading, one per cycle while
// draining with res_stall low; no items are taken while the chain drains.
// Reset: all cells empty, drop flag clear, output register empty.
// ---------------------------------------------------------------------------
// merge_sorter
// Sorts a set of signed values in ascending order with a chain of insertion
// cells and emits them in order, flagging sets that overflowed the chain.
// ---------------------------------------------------------------------------
`default_nettype none

`include "merge_sorter_macros.svh"

module merge_sorter #(
	parameter int unsigned MAX_ELEMS = ms_pkg::DEFAULT_MAX_ELEMS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         elem_valid,
	output logic              elem_stall,
	input  wire ms_pkg::in_t  elem,
	output logic              res_valid,
	input  wire logic         res_stall,
	output ms_pkg::out_t      res
);

	ms_pkg::state_t state_q, state_d;
	ms_pkg::ctl_t   ctl;
	ms_pkg::slot_t  slots [MAX_ELEMS];
	logic           gts   [MAX_ELEMS];
	logic           drop_q;
	logic           out_valid_q;
	ms_pkg::out_t   out_q;
	logic           take;
	logic           full;
	logic           out_free;
	logic           last_pop;
	logic           sorted_ok;
	logic           packed_ok;

	assign full     = slots[MAX_ELEMS-1].valid;
	assign take     = elem_valid && !elem_stall;
	assign out_free = !out_valid_q || !res_stall;
	assign last_pop = ctl.pop && !slots[1].valid;

	always_comb begin
		state_d    = state_q;
		ctl        = '{insert: 1'b0, pop: 1'b0};
		elem_stall = 1'b0;
		unique case (state_q)
			ms_pkg::ST_LOAD: begin
				ctl.insert = take && !full;
				if (take && elem.last) begin
					state_d = ms_pkg::ST_EMIT;
				end
			end
			ms_pkg::ST_EMIT: begin
				elem_stall = 1'b1;
				ctl.pop    = out_free && slots[0].valid;
				if (ctl.pop && !slots[1].valid) begin
					state_d = ms_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = ms_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ms_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
		ms_pkg::slot_t left_slot;
		ms_pkg::slot_t right_slot;
		logic          left_gt;

		if (i == 0) begin : g_head
			assign left_slot = '{valid: 1'b0, value: '0};
			assign left_gt   = 1'b0;
		end else begin : g_mid
			assign left_slot = slots[i-1];
			assign left_gt   = gts[i-1];
		end

		if (i == MAX_ELEMS - 1) begin : g_tail
			assign right_slot = '{valid: 1'b0, value: '0};
		end else begin : g_body
			assign right_slot = slots[i+1];
		end

		ms_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_value (elem.value),
			.left      (left_slot),
			.left_gt   (left_gt),
			.right     (right_slot),
			.slot      (slots[i]),
			.gt        (gts[i])
		);
	end

	// A value that arrives at a full chain, the closing one included, is lost.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b0;
		end else if (last_pop) begin
			drop_q <= 1'b0;
		end else if (ctl.insert == 1'b0 && take && full) begin
			drop_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.pop) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			out_q <= '{sorted_value: slots[0].value,
			           last_out:     !slots[1].valid,
			           overflow:     drop_q};
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		sorted_ok = 1'b1;
		packed_ok = 1'b1;
		for (int i = 0; i < MAX_ELEMS - 1; i++) begin
			if (slots[i].valid && slots[i+1].valid
			    && slots[i].value > slots[i+1].value) begin
				sorted_ok = 1'b0;
			end
			if (!slots[i].valid && slots[i+1].valid) begin
				packed_ok = 1'b0;
			end
		end
	end

	`MS_CHECK(a_chain_sorted, sorted_ok, "cell chain out of order")
	`MS_CHECK(a_chain_packed, packed_ok, "gap in cell chain")
	`MS_IMPLY(a_last_marked, last_pop,
		res_valid && res.last_out && !slots[0].valid && state_q == ms_pkg::ST_LOAD,
		"final pop did not end the set")
	`MS_IMPLY(a_close_emits, take && elem.last,
		state_q == ms_pkg::ST_EMIT && slots[0].valid,
		"closing item did not start emission")

endmodule

`default_nettype wire
